// File: hdl/blpt_pkg.sv
// Bank last-program table: shared types and codes.
// Used by bank_last_program_table_core; no dependencies.
package blpt_pkg;

  localparam int TABLE_ENTRIES_DEF = 48;
  localparam int KEY_W             = 24;
  localparam int PROG_W            = 8;
  localparam int ENTRY_W           = KEY_W + PROG_W;
  localparam int COUNT_OUT_W       = 6;

  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_GET   = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  localparam logic [2:0] ST_UNCHANGED = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_APPENDED  = 3'd2;
  localparam logic [2:0] ST_DROPPED   = 3'd3;
  localparam logic [2:0] ST_NOT_SET   = 3'd4;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] synth_id;
    logic [7:0] bank_msb;
    logic [7:0] bank_lsb;
    logic [7:0] program_in;
  } cmd_word_t;

  typedef struct packed {
    logic                   hit;
    logic [PROG_W-1:0]      program_out;
    logic [2:0]             set_status;
    logic                   was_dirty;
    logic [COUNT_OUT_W-1:0] entry_count;
  } rsp_word_t;

endpackage

// File: hdl/blpt_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module blpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 48,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/bank_last_program_table_core.sv
// Bank last-program table core: key to program lookup with insertion-order store.
// Depends on blpt_pkg and blpt_ram.
//
// One command word is taken when start is high and busy is low; busy stays high
// until its response word has been shown. The response is on rsp for exactly one
// cycle with done high and cannot be stalled, so the receiver must take it then.
// Set and get walk the valid entries of the entry RAM one per cycle, first match
// wins, and stop at a match or after the last valid entry; flush, the unused code
// and any command on an empty table skip the walk and go straight to resolve.
// The next command can be taken in the cycle done is high.
module bank_last_program_table_core #(
  parameter int TABLE_ENTRIES = blpt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  blpt_pkg::cmd_word_t   cmd,
  output logic                  busy,
  output logic                  done,
  output blpt_pkg::rsp_word_t   rsp
);

  localparam int AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int EXT_W = CNT_W + blpt_pkg::COUNT_OUT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE
  } state_t;

  state_t                       state;
  blpt_pkg::cmd_word_t          cur;
  logic                         was_dirty;
  logic                         dirty;
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             scan_idx;
  logic [AW-1:0]                cmp_idx;
  logic                         cmp_valid;
  logic                         found;
  logic [AW-1:0]                found_idx;
  logic [blpt_pkg::PROG_W-1:0]  found_prog;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [blpt_pkg::ENTRY_W-1:0] ram_wdata;
  logic                         ram_re;
  logic [blpt_pkg::ENTRY_W-1:0] ram_rdata;

  logic [blpt_pkg::KEY_W-1:0]   key;
  logic                         match;
  logic                         scan_end;
  logic [CNT_W-1:0]             count_next;
  logic                         dirty_next;
  logic [2:0]                   status_next;
  logic                         hit_next;
  logic [blpt_pkg::PROG_W-1:0]  prog_next;
  logic [EXT_W-1:0]             count_ext;

  blpt_ram #(
    .WIDTH (blpt_pkg::ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign key       = {cur.synth_id, cur.bank_msb, cur.bank_lsb};
  assign match     = cmp_valid && (ram_rdata[blpt_pkg::ENTRY_W-1:blpt_pkg::PROG_W] == key);
  assign scan_end  = (scan_idx == count);
  assign ram_re    = (state == S_SCAN) && !match && !scan_end;
  assign ram_wdata = {key, cur.program_in};
  assign busy      = (state != S_IDLE);
  assign count_ext = {{blpt_pkg::COUNT_OUT_W{1'b0}}, count_next};

  // Resolve the command from the scan outcome.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = found_idx;
    count_next  = count;
    dirty_next  = dirty;
    status_next = blpt_pkg::ST_NOT_SET;
    hit_next    = 1'b0;
    prog_next   = '0;
    if (state == S_RESOLVE) begin
      case (cur.operation)
        blpt_pkg::OP_SET: begin
          hit_next = found;
          if (found) begin
            if (found_prog == cur.program_in) begin
              status_next = blpt_pkg::ST_UNCHANGED;
            end else begin
              ram_we      = 1'b1;
              dirty_next  = 1'b1;
              status_next = blpt_pkg::ST_UPDATED;
            end
          end else if (count < CNT_W'(TABLE_ENTRIES)) begin
            ram_we      = 1'b1;
            ram_waddr   = count[AW-1:0];
            count_next  = count + 1'b1;
            dirty_next  = 1'b1;
            status_next = blpt_pkg::ST_APPENDED;
          end else begin
            status_next = blpt_pkg::ST_DROPPED;
          end
        end
        blpt_pkg::OP_GET: begin
          hit_next  = found;
          prog_next = found ? found_prog : '0;
        end
        blpt_pkg::OP_FLUSH: begin
          dirty_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      dirty     <= 1'b0;
      count     <= '0;
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur       <= cmd;
            was_dirty <= dirty;
            found     <= 1'b0;
            scan_idx  <= '0;
            cmp_valid <= 1'b0;
            if ((cmd.operation == blpt_pkg::OP_SET || cmd.operation == blpt_pkg::OP_GET)
                && count != '0) begin
              state <= S_SCAN;
            end else begin
              state <= S_RESOLVE;
            end
          end
        end
        S_SCAN: begin
          if (match) begin
            found      <= 1'b1;
            found_idx  <= cmp_idx;
            found_prog <= ram_rdata[blpt_pkg::PROG_W-1:0];
            state      <= S_RESOLVE;
          end else if (scan_end) begin
            state <= S_RESOLVE;
          end else begin
            cmp_valid <= 1'b1;
            cmp_idx   <= scan_idx[AW-1:0];
            scan_idx  <= scan_idx + 1'b1;
          end
        end
        S_RESOLVE: begin
          count           <= count_next;
          dirty           <= dirty_next;
          rsp.hit         <= hit_next;
          rsp.program_out <= prog_next;
          rsp.set_status  <= status_next;
          rsp.was_dirty   <= was_dirty;
          rsp.entry_count <= count_ext[blpt_pkg::COUNT_OUT_W-1:0];
          done            <= 1'b1;
          state           <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: test/tb.sv
// Testbench for bank_last_program_table_core: directed table rows, then random key traffic.
// Every response word is checked, against a typed row's values or else an in-bench model of the bank table.
// Depends on blpt_pkg and the core RTL.
`timescale 1ns / 100ps

module tb;

  localparam int          TABLE_ENTRIES = blpt_pkg::TABLE_ENTRIES_DEF;
  localparam logic [1:0]  OP_NONE       = 2'd3;
  localparam int          RAND_WORDS    = 1580;
  localparam int          STALL_LIMIT   = 1000;
  localparam int          SETTLE_CYCLES = TABLE_ENTRIES + 8;

  typedef enum logic [1:0] {ROW_TYPED, ROW_PRED, ROW_FILL} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    blpt_pkg::cmd_word_t word;
    blpt_pkg::rsp_word_t want;
  } stim_row_t;

  logic                clk;
  logic                rst   = 1'b1;
  logic                start = 1'b0;
  blpt_pkg::cmd_word_t cmd   = '0;
  logic                busy;
  logic                done;
  blpt_pkg::rsp_word_t rsp;

  logic [blpt_pkg::KEY_W-1:0]  tbl_key  [TABLE_ENTRIES];
  logic [blpt_pkg::PROG_W-1:0] tbl_prog [TABLE_ENTRIES];
  int                          tbl_count = 0;
  logic                        tbl_dirty = 1'b0;

  blpt_pkg::rsp_word_t rsp_pending [$];
  stim_row_t           dir_rows [$];
  int                  mismatches    = 0;
  int                  words_checked = 0;
  int                  stall_cycles  = 0;

  bank_last_program_table_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) DUT (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (cmd),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic blpt_pkg::rsp_word_t bank_table_step(blpt_pkg::cmd_word_t w);
    blpt_pkg::rsp_word_t        r;
    logic [blpt_pkg::KEY_W-1:0] key;
    int                         idx;
    int                         i;
    key         = {w.synth_id, w.bank_msb, w.bank_lsb};
    r           = '0;
    r.set_status = blpt_pkg::ST_NOT_SET;
    r.was_dirty = tbl_dirty;
    idx         = -1;
    for (i = 0; i < tbl_count; i++) begin
      if (idx < 0 && tbl_key[i] == key) idx = i;
    end
    case (w.operation)
      blpt_pkg::OP_SET: begin
        if (idx >= 0) begin
          r.hit = 1'b1;
          if (tbl_prog[idx] == w.program_in) begin
            r.set_status = blpt_pkg::ST_UNCHANGED;
          end else begin
            tbl_prog[idx] = w.program_in;
            tbl_dirty     = 1'b1;
            r.set_status  = blpt_pkg::ST_UPDATED;
          end
        end else if (tbl_count < TABLE_ENTRIES) begin
          tbl_key[tbl_count]  = key;
          tbl_prog[tbl_count] = w.program_in;
          tbl_count++;
          tbl_dirty    = 1'b1;
          r.set_status = blpt_pkg::ST_APPENDED;
        end else begin
          r.set_status = blpt_pkg::ST_DROPPED;
        end
      end
      blpt_pkg::OP_GET: begin
        if (idx >= 0) begin
          r.hit         = 1'b1;
          r.program_out = tbl_prog[idx];
        end
      end
      blpt_pkg::OP_FLUSH: tbl_dirty = 1'b0;
      default: ;
    endcase
    r.entry_count = blpt_pkg::COUNT_OUT_W'(tbl_count);
    return r;
  endfunction

  function automatic stim_row_t mk_row(row_kind_t k, logic [1:0] op, logic [7:0] s,
                                       logic [7:0] m, logic [7:0] l, logic [7:0] p,
                                       logic h, logic [7:0] po, logic [2:0] st,
                                       logic wd, int cnt);
    stim_row_t r;
    r.kind                 = k;
    r.word                 = '{operation: op, synth_id: s, bank_msb: m, bank_lsb: l,
                               program_in: p};
    r.want.hit             = h;
    r.want.program_out     = po;
    r.want.set_status      = st;
    r.want.was_dirty       = wd;
    r.want.entry_count     = blpt_pkg::COUNT_OUT_W'(cnt);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on word %0d, %s: got %0h want %0h",
             $realtime, words_checked, what, got, want);
    mismatches++;
  endtask

  task automatic check_word(blpt_pkg::rsp_word_t got);
    blpt_pkg::rsp_word_t want;
    if (rsp_pending.size() == 0) begin
      report_mismatch("word with none pending", 32'(got), 32'd0);
      return;
    end
    want = rsp_pending.pop_front();
    if (got.hit !== want.hit) report_mismatch("hit", 32'(got.hit), 32'(want.hit));
    if (got.program_out !== want.program_out)
      report_mismatch("program_out", 32'(got.program_out), 32'(want.program_out));
    if (got.set_status !== want.set_status)
      report_mismatch("set_status", 32'(got.set_status), 32'(want.set_status));
    if (got.was_dirty !== want.was_dirty)
      report_mismatch("was_dirty", 32'(got.was_dirty), 32'(want.was_dirty));
    if (got.entry_count !== want.entry_count)
      report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
    words_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) check_word(rsp);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_word(blpt_pkg::cmd_word_t w, bit typed, blpt_pkg::rsp_word_t want,
                           bit may_idle);
    blpt_pkg::rsp_word_t pred;
    logic [63:0]         noise;
    int                  gap;
    gap = 0;
    if (may_idle && $urandom_range(99) < 33)
      gap = ($urandom_range(9) == 0) ? $urandom_range(60, 4) : $urandom_range(3, 1);
    if (gap > 0) begin
      noise = {$urandom, $urandom};
      start <= 1'b0;
      cmd   <= noise[$bits(blpt_pkg::cmd_word_t)-1:0];
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = bank_table_step(w);
    rsp_pending.push_back(typed ? want : pred);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (rsp_pending.size() != 0);
  endtask

  initial begin
    blpt_pkg::cmd_word_t        w;
    logic [blpt_pkg::KEY_W-1:0] key;
    int                         r;
    int                         n;

    dir_rows.push_back(mk_row(ROW_TYPED, blpt_pkg::OP_GET,   8'hFF, 8'hFF, 8'hFF, 8'h00,
                              0, 8'h00, blpt_pkg::ST_NOT_SET,   0, 0));
    dir_rows.push_back(mk_row(ROW_TYPED, blpt_pkg::OP_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00,
                              0, 8'h00, blpt_pkg::ST_NOT_SET,   0, 0));
    dir_rows.push_back(mk_row(ROW_TYPED, OP_NONE,            8'h00, 8'h00, 8'h00, 8'h00,
                              0, 8'h00, blpt_pkg::ST_NOT_SET,   0, 0));
    dir_rows.push_back(mk_row(ROW_TYPED, blpt_pkg::OP_SET,   8'h00, 8'h00, 8'h00, 8'h00,
                              0, 8'h00, blpt_pkg::ST_APPENDED,  0, 1));
    dir_rows.push_back(mk_row(ROW_TYPED, blpt_pkg::OP_SET,   8'h00, 8'h00, 8'h00, 8'h00,
                              1, 8'h00, blpt_pkg::ST_UNCHANGED, 1, 1));
    dir_rows.push_back(mk_row(ROW_TYPED, blpt_pkg::OP_GET,   8'h00, 8'h00, 8'h00, 8'hFF,
                              1, 8'h00, blpt_pkg::ST_NOT_SET,   1, 1));
    dir_rows.push_back(mk_row(ROW_TYPED, blpt_pkg::OP_SET,   8'hFF, 8'hFF, 8'hFF, 8'hFF,
                              0, 8'h00, blpt_pkg::ST_APPENDED,  1, 2));
    dir_rows.push_back(mk_row(ROW_TYPED, blpt_pkg::OP_GET,   8'hFF, 8'hFF, 8'hFF, 8'h00,
                              1, 8'hFF, blpt_pkg::ST_NOT_SET,   1, 2));
    dir_rows.push_back(mk_row(ROW_TYPED, blpt_pkg::OP_SET,   8'hFF, 8'hFF, 8'hFF, 8'h00,
                              1, 8'h00, blpt_pkg::ST_UPDATED,   1, 2));
    dir_rows.push_back(mk_row(ROW_TYPED, blpt_pkg::OP_FLUSH, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                              0, 8'h00, blpt_pkg::ST_NOT_SET,   1, 2));
    dir_rows.push_back(mk_row(ROW_TYPED, blpt_pkg::OP_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00,
                              0, 8'h00, blpt_pkg::ST_NOT_SET,   0, 2));
    dir_rows.push_back(mk_row(ROW_TYPED, blpt_pkg::OP_SET,   8'hFF, 8'hFF, 8'hFF, 8'h00,
                              1, 8'h00, blpt_pkg::ST_UNCHANGED, 0, 2));
    dir_rows.push_back(mk_row(ROW_TYPED, OP_NONE,            8'hFF, 8'hFF, 8'hFF, 8'hFF,
                              0, 8'h00, blpt_pkg::ST_NOT_SET,   0, 2));
    dir_rows.push_back(mk_row(ROW_TYPED, blpt_pkg::OP_GET,   8'h00, 8'hFF, 8'h00, 8'h00,
                              0, 8'h00, blpt_pkg::ST_NOT_SET,   0, 2));
    dir_rows.push_back(mk_row(ROW_PRED,  blpt_pkg::OP_SET,   8'h00, 8'hFF, 8'h00, 8'h80,
                              0, 8'h00, blpt_pkg::ST_NOT_SET,   0, 0));
    dir_rows.push_back(mk_row(ROW_PRED,  blpt_pkg::OP_SET,   8'hFF, 8'hFF, 8'hFF, 8'h5A,
                              0, 8'h00, blpt_pkg::ST_NOT_SET,   0, 0));
    dir_rows.push_back(mk_row(ROW_FILL,  blpt_pkg::OP_SET,   8'h00, 8'h00, 8'h00, 8'h00,
                              0, 8'h00, blpt_pkg::ST_NOT_SET,   0, 0));
    dir_rows.push_back(mk_row(ROW_TYPED, blpt_pkg::OP_SET,   8'h12, 8'h34, 8'h56, 8'h07,
                              0, 8'h00, blpt_pkg::ST_DROPPED,   1, TABLE_ENTRIES));
    dir_rows.push_back(mk_row(ROW_TYPED, blpt_pkg::OP_GET,   8'h12, 8'h34, 8'h56, 8'h00,
                              0, 8'h00, blpt_pkg::ST_NOT_SET,   1, TABLE_ENTRIES));
    dir_rows.push_back(mk_row(ROW_PRED,  blpt_pkg::OP_SET,   8'hFF, 8'hFF, 8'hFF, 8'h81,
                              0, 8'h00, blpt_pkg::ST_NOT_SET,   0, 0));
    dir_rows.push_back(mk_row(ROW_TYPED, blpt_pkg::OP_GET,   8'h00, 8'h00, 8'h00, 8'h00,
                              1, 8'h00, blpt_pkg::ST_NOT_SET,   1, TABLE_ENTRIES));
    dir_rows.push_back(mk_row(ROW_PRED,  blpt_pkg::OP_GET,   8'h00, 8'hFF, 8'h00, 8'h00,
                              0, 8'h00, blpt_pkg::ST_NOT_SET,   0, 0));
    dir_rows.push_back(mk_row(ROW_TYPED, blpt_pkg::OP_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00,
                              0, 8'h00, blpt_pkg::ST_NOT_SET,   1, TABLE_ENTRIES));
    dir_rows.push_back(mk_row(ROW_TYPED, blpt_pkg::OP_SET,   8'hAB, 8'hCD, 8'hEF, 8'hFF,
                              0, 8'h00, blpt_pkg::ST_DROPPED,   0, TABLE_ENTRIES));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_FILL) begin
        while (tbl_count < TABLE_ENTRIES) begin
          w.operation  = blpt_pkg::OP_SET;
          w.synth_id   = 8'(tbl_count);
          w.bank_msb   = 8'(tbl_count * 5);
          w.bank_lsb   = ~8'(tbl_count);
          w.program_in = 8'($urandom_range(255));
          send_word(w, 1'b0, '0, 1'b1);
        end
      end else begin
        send_word(dir_rows[i].word, dir_rows[i].kind == ROW_TYPED, dir_rows[i].want, 1'b1);
      end
    end

    drain_results();

    for (n = 0; n < RAND_WORDS; n++) begin
      if ($urandom_range(39) == 0) drain_results();
      r = $urandom_range(99);
      if (r < 45)      w.operation = blpt_pkg::OP_SET;
      else if (r < 85) w.operation = blpt_pkg::OP_GET;
      else if (r < 95) w.operation = blpt_pkg::OP_FLUSH;
      else             w.operation = OP_NONE;
      if (tbl_count == 0 || $urandom_range(4) == 0)
        key = blpt_pkg::KEY_W'($urandom);
      else
        key = tbl_key[$urandom_range(tbl_count - 1)];
      {w.synth_id, w.bank_msb, w.bank_lsb} = key;
      w.program_in = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
      send_word(w, 1'b0, '0, !(n >= 600 && n < 900));
    end

    start <= 1'b0;
    while (rsp_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
